[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Each check is clocked on the given
// clock and switched off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that expr never holds.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[rtl/es2c_pkg.sv]
// ----------------------------------------------------------------------------
// es2c_pkg
// Constants, reciprocal multipliers, tables and the pipeline work type for
// the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package es2c_pkg;

    // Default width of the seconds input
    localparam int ES2C_SECONDS_W = 40;

    // Quotient bits retired by each long-division stage
    localparam int DIV_BITS_PER_STAGE = 4;

    // Output field widths
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;

    // Time of day
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_DAY    = 86400;
    localparam int HOURS_PER_DAY      = 24;
    localparam int SOD_W              = 17;   // second of day
    localparam int SOH_W              = 12;   // second of hour

    // Calendar eras of 400 years, counted from 0000-03-01
    localparam int ERA_DAYS      = 146097;
    localparam int ERA_YEARS     = 400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DOE_W         = 18;        // day of era
    localparam int YOE_W         = 9;         // year of era
    localparam int DOY_W         = 9;         // day of March-based year
    localparam int MP_W          = 4;         // March-based month index
    localparam int MP_ARG_W      = 11;        // 5 * doy + 2

    // Seconds from 0000-03-01 to 1970-01-01, a whole number of days
    localparam longint unsigned EPOCH_SEC_OFFSET = 64'd719468 * 64'd86400;
    localparam int EPOCH_OFFSET_W = 36;

    // Weekday: day of era 0 falls on a Wednesday, Sunday codes as 1
    localparam int DOE_WDAY_BIAS  = 3;
    localparam int WEEKDAY_SUNDAY = 1;

    // Month mapping from the March-based index
    localparam int MP_JANUARY    = 10;
    localparam int MP_MARCH_ADD  = 3;
    localparam int MP_JAN_SUB    = 9;
    localparam int MONTHS_PER_YR = 12;
    localparam int MONTH_FEB     = 2;
    localparam int FEB_MAX_DAYS  = 29;

    // Floor division by constants: x * MUL >> SH is exact for x < 2**XW
    // with SH = XW + clog2(divisor).
    localparam int Q1460_SH = DOE_W + $clog2(1460);
    localparam longint unsigned Q1460_MUL = ((64'd1 << Q1460_SH) + 1460 - 1) / 1460;
    localparam int Q1460_W  = 7;

    localparam int Q36524_SH = DOE_W + $clog2(36524);
    localparam longint unsigned Q36524_MUL =
        ((64'd1 << Q36524_SH) + 36524 - 1) / 36524;
    localparam int Q36524_W  = 3;

    localparam int Q365_SH = DOE_W + $clog2(DAYS_PER_YEAR);
    localparam longint unsigned Q365_MUL =
        ((64'd1 << Q365_SH) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;

    localparam int Q100_SH = YOE_W + $clog2(100);
    localparam longint unsigned Q100_MUL = ((64'd1 << Q100_SH) + 100 - 1) / 100;
    localparam int Q100_W  = 2;

    localparam int Q3600_SH = SOD_W + $clog2(SECONDS_PER_HOUR);
    localparam longint unsigned Q3600_MUL =
        ((64'd1 << Q3600_SH) + SECONDS_PER_HOUR - 1) / SECONDS_PER_HOUR;

    localparam int Q60_SH = SOH_W + $clog2(SECONDS_PER_MINUTE);
    localparam longint unsigned Q60_MUL =
        ((64'd1 << Q60_SH) + SECONDS_PER_MINUTE - 1) / SECONDS_PER_MINUTE;

    localparam int Q153_SH = MP_ARG_W + $clog2(153);
    localparam longint unsigned Q153_MUL = ((64'd1 << Q153_SH) + 153 - 1) / 153;

    // Number of register stages after the two long divisions
    localparam int TAIL_STAGES = 7;

    // Fields carried through the date and time stages
    typedef struct packed {
        logic [DOE_W-1:0]    doe;
        logic [YEAR_W-1:0]   era_lo;
        logic [SOD_W-1:0]    sod;
        logic [Q1460_W-1:0]  q1460;
        logic [Q36524_W-1:0] q36524;
        logic                last_day;
        logic [DOE_W-1:0]    num;
        logic [YOE_W-1:0]    yoe;
        logic [DOE_W-1:0]    p365;
        logic [Q100_W-1:0]   c100;
        logic [DOY_W-1:0]    doy;
        logic [MP_W-1:0]     mp;
        logic [HOUR_W-1:0]   hour;
        logic [SOH_W-1:0]    soh;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
        logic [WDAY_W-1:0]   weekday;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [MDAY_W-1:0]   mday;
    } cal_work_t;

    // First day of each March-based month, counted within the year
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] first;
        case (mp)
            4'd0:    first = 9'd0;
            4'd1:    first = 9'd31;
            4'd2:    first = 9'd61;
            4'd3:    first = 9'd92;
            4'd4:    first = 9'd122;
            4'd5:    first = 9'd153;
            4'd6:    first = 9'd184;
            4'd7:    first = 9'd214;
            4'd8:    first = 9'd245;
            4'd9:    first = 9'd275;
            4'd10:   first = 9'd306;
            4'd11:   first = 9'd337;
            default: first = 9'd0;
        endcase
        return first;
    endfunction

    // Residue mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7_doe(input logic [DOE_W-1:0] x);
        logic [5:0] sum1;
        logic [3:0] sum2;
        logic [3:0] sum3;
        sum1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
             + 6'(x[14:12]) + 6'(x[17:15]);
        sum2 = 4'(sum1[2:0]) + 4'(sum1[5:3]);
        sum3 = 4'(sum2[2:0]) + 4'(sum2[3]);
        return (sum3 >= 4'd7) ? 3'(sum3 - 4'd7) : sum3[2:0];
    endfunction

endpackage

[rtl/epoch_seconds_to_calendar_core.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Streaming converter from seconds since 1970-01-01 00:00:00 to Gregorian
// date, time of day and day of week.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one result per item, in order. Two long divisions by constants,
// by seconds per day and by days per 400-year era, each retire four
// quotient bits per stage, and seven stages of reciprocal multiplies then
// split the day of era into year, month and day and the second of day
// into hours, minutes and seconds. Every stage has its own valid bit; a
// stalled output holds its result while empty stages upstream keep
// filling. Weekday is 1 for Sunday through 7 for Saturday; the year is
// given modulo 65536.
`include "assert_macros.svh"

module epoch_seconds_to_calendar_core
    import es2c_pkg::*;
#(
    parameter int SECONDS_WIDTH = ES2C_SECONDS_W
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     epoch_valid,
    output logic                     epoch_ready,
    input  logic [SECONDS_WIDTH-1:0] epoch_seconds,

    output logic                     cal_valid,
    input  logic                     cal_ready,
    output logic [SEC_W-1:0]         second_of_minute,
    output logic [MIN_W-1:0]         minute_of_hour,
    output logic [HOUR_W-1:0]        hour_of_day,
    output logic [WDAY_W-1:0]        weekday,
    output logic [YEAR_W-1:0]        year_number,
    output logic [MONTH_W-1:0]       month_number,
    output logic [MDAY_W-1:0]        day_of_month
);

    // Seconds from 0000-03-01, days from 0000-03-01, eras
    localparam int T_W = ((SECONDS_WIDTH > EPOCH_OFFSET_W) ? SECONDS_WIDTH
                                                           : EPOCH_OFFSET_W) + 1;
    localparam int Z_W = T_W - (SOD_W - 1);
    localparam int E_W = Z_W - (DOE_W - 1);

    // Long-division stage counts and padded work widths
    localparam int NS1 = (T_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int NS2 = (Z_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int TW1 = NS1 * DIV_BITS_PER_STAGE;
    localparam int TW2 = NS2 * DIV_BITS_PER_STAGE;
    localparam int NST = NS1 + NS2 + TAIL_STAGES;
    localparam int D2_BASE   = NS1;
    localparam int TAIL_BASE = NS1 + NS2;

    // Stage valid bits and flow control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST:0]   free;
    logic [NST-1:0] ld;

    // Stage payload registers
    logic [SOD_W-1:0] d1_rem_reg  [NS1];
    logic [TW1-1:0]   d1_work_reg [NS1];
    logic [SOD_W-1:0] d1_rem_next [NS1];
    logic [TW1-1:0]   d1_work_next[NS1];

    logic [DOE_W-1:0] d2_rem_reg  [NS2];
    logic [TW2-1:0]   d2_work_reg [NS2];
    logic [SOD_W-1:0] d2_sod_reg  [NS2];
    logic [DOE_W-1:0] d2_rem_next [NS2];
    logic [TW2-1:0]   d2_work_next[NS2];
    logic [SOD_W-1:0] d2_sod_next [NS2];

    cal_work_t tail_reg [TAIL_STAGES];
    cal_work_t tail_next[TAIL_STAGES];
    cal_work_t tail_seed;

    logic [T_W-1:0] total_sec;

    // Stage i takes a new item when it is empty or its item moves on
    assign free[NST] = cal_ready;
    for (genvar i = 0; i < NST; i++) begin : g_free
        assign free[i] = !vld_reg[i] || free[i+1];
    end

    assign vld_in      = {vld_reg[NST-2:0], epoch_valid};
    assign ld          = free[NST-1:0] & vld_in;
    assign epoch_ready = free[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (free[NST-1:0] & vld_in) | (~free[NST-1:0] & vld_reg);
        end
    end

    // Rebase the count to 0000-03-01
    assign total_sec = T_W'(epoch_seconds) + T_W'(EPOCH_SEC_OFFSET);

    // Divide by seconds per day, four quotient bits per stage
    for (genvar s = 0; s < NS1; s++) begin : g_d1
        logic [SOD_W-1:0] rem_in;
        logic [TW1-1:0]   work_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = TW1'(total_sec);
        end
        else begin : g_chain
            assign rem_in  = d1_rem_reg[s-1];
            assign work_in = d1_work_reg[s-1];
        end

        always_comb
        begin : p_step
            logic [SOD_W:0]   trial;
            logic [SOD_W-1:0] rem_v;
            logic [TW1-1:0]   work_v;
            rem_v  = rem_in;
            work_v = work_in;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                trial = {rem_v, work_v[TW1-1]};
                if (trial >= (SOD_W+1)'(SECONDS_PER_DAY))
                begin
                    trial  = trial - (SOD_W+1)'(SECONDS_PER_DAY);
                    work_v = {work_v[TW1-2:0], 1'b1};
                end
                else
                begin
                    work_v = {work_v[TW1-2:0], 1'b0};
                end
                rem_v = trial[SOD_W-1:0];
            end
            d1_rem_next[s]  = rem_v;
            d1_work_next[s] = work_v;
        end
    end

    // Divide days by days per era, carry the second of day along
    for (genvar s = 0; s < NS2; s++) begin : g_d2
        logic [DOE_W-1:0] rem_in;
        logic [TW2-1:0]   work_in;
        logic [SOD_W-1:0] sod_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = TW2'(d1_work_reg[NS1-1][Z_W-1:0]);
            assign sod_in  = d1_rem_reg[NS1-1];
        end
        else begin : g_chain
            assign rem_in  = d2_rem_reg[s-1];
            assign work_in = d2_work_reg[s-1];
            assign sod_in  = d2_sod_reg[s-1];
        end

        always_comb
        begin : p_step
            logic [DOE_W:0]   trial;
            logic [DOE_W-1:0] rem_v;
            logic [TW2-1:0]   work_v;
            rem_v  = rem_in;
            work_v = work_in;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                trial = {rem_v, work_v[TW2-1]};
                if (trial >= (DOE_W+1)'(ERA_DAYS))
                begin
                    trial  = trial - (DOE_W+1)'(ERA_DAYS);
                    work_v = {work_v[TW2-2:0], 1'b1};
                end
                else
                begin
                    work_v = {work_v[TW2-2:0], 1'b0};
                end
                rem_v = trial[DOE_W-1:0];
            end
            d2_rem_next[s]  = rem_v;
            d2_work_next[s] = work_v;
            d2_sod_next[s]  = sod_in;
        end
    end

    // Seed the date and time stages from the era division
    always_comb
    begin
        tail_seed        = '0;
        tail_seed.doe    = d2_rem_reg[NS2-1];
        tail_seed.sod    = d2_sod_reg[NS2-1];
        tail_seed.era_lo = YEAR_W'(d2_work_reg[NS2-1][E_W-1:0]);
    end

    // Date and time stages
    for (genvar k = 0; k < TAIL_STAGES; k++) begin : g_tail
        cal_work_t cur;
        cal_work_t nxt;

        if (k == 0) begin : g_first
            assign cur = tail_seed;
        end
        else begin : g_chain
            assign cur = tail_reg[k-1];
        end

        assign tail_next[k] = nxt;

        if (k == 0) begin : g_stage_a
            // Split out century and leap corrections, hour, weekday, era years
            always_comb
            begin : p_calc
                logic [2*DOE_W:0] prod_1460;
                logic [2*DOE_W:0] prod_36524;
                logic [2*SOD_W:0] prod_3600;
                prod_1460  = (2*DOE_W+1)'(cur.doe) * (2*DOE_W+1)'(Q1460_MUL);
                prod_36524 = (2*DOE_W+1)'(cur.doe) * (2*DOE_W+1)'(Q36524_MUL);
                prod_3600  = (2*SOD_W+1)'(cur.sod) * (2*SOD_W+1)'(Q3600_MUL);
                nxt          = cur;
                nxt.q1460    = prod_1460[Q1460_SH +: Q1460_W];
                nxt.q36524   = prod_36524[Q36524_SH +: Q36524_W];
                nxt.last_day = (cur.doe == DOE_W'(ERA_DAYS - 1));
                nxt.hour     = prod_3600[Q3600_SH +: HOUR_W];
                nxt.weekday  = mod7_doe(cur.doe + DOE_W'(DOE_WDAY_BIAS))
                             + WDAY_W'(WEEKDAY_SUNDAY);
                nxt.year     = cur.era_lo * YEAR_W'(ERA_YEARS);
            end
        end
        else if (k == 1) begin : g_stage_b
            // Form the day count that divides evenly into years; second of hour
            always_comb
            begin
                nxt     = cur;
                nxt.num = cur.doe - DOE_W'(cur.q1460) + DOE_W'(cur.q36524)
                        - DOE_W'(cur.last_day);
                nxt.soh = SOH_W'(cur.sod - SOD_W'(cur.hour) * SOD_W'(SECONDS_PER_HOUR));
            end
        end
        else if (k == 2) begin : g_stage_c
            // Year of era and minute
            always_comb
            begin : p_calc
                logic [2*DOE_W:0] prod_365;
                logic [2*SOH_W:0] prod_60;
                prod_365   = (2*DOE_W+1)'(cur.num) * (2*DOE_W+1)'(Q365_MUL);
                prod_60    = (2*SOH_W+1)'(cur.soh) * (2*SOH_W+1)'(Q60_MUL);
                nxt        = cur;
                nxt.yoe    = prod_365[Q365_SH +: YOE_W];
                nxt.minute = prod_60[Q60_SH +: MIN_W];
            end
        end
        else if (k == 3) begin : g_stage_d
            // Days in whole years of era, century count, second, year sum
            always_comb
            begin : p_calc
                logic [2*YOE_W:0] prod_100;
                prod_100   = (2*YOE_W+1)'(cur.yoe) * (2*YOE_W+1)'(Q100_MUL);
                nxt        = cur;
                nxt.p365   = DOE_W'(cur.yoe) * DOE_W'(DAYS_PER_YEAR);
                nxt.c100   = prod_100[Q100_SH +: Q100_W];
                nxt.second = SEC_W'(cur.soh - SOH_W'(cur.minute)
                                              * SOH_W'(SECONDS_PER_MINUTE));
                nxt.year   = cur.year + YEAR_W'(cur.yoe);
            end
        end
        else if (k == 4) begin : g_stage_e
            // Day within the March-based year
            always_comb
            begin
                nxt     = cur;
                nxt.doy = DOY_W'(cur.doe - (cur.p365 + DOE_W'(cur.yoe[YOE_W-1:2])
                                            - DOE_W'(cur.c100)));
            end
        end
        else if (k == 5) begin : g_stage_f
            // March-based month index
            always_comb
            begin : p_calc
                logic [MP_ARG_W-1:0]   mp_arg;
                logic [2*MP_ARG_W:0]   prod_153;
                mp_arg   = (MP_ARG_W'(cur.doy) << 2) + MP_ARG_W'(cur.doy) + MP_ARG_W'(2);
                prod_153 = (2*MP_ARG_W+1)'(mp_arg) * (2*MP_ARG_W+1)'(Q153_MUL);
                nxt      = cur;
                nxt.mp   = prod_153[Q153_SH +: MP_W];
            end
        end
        else begin : g_stage_g
            // Day of month, civil month, carry January and February to next year
            always_comb
            begin
                nxt      = cur;
                nxt.mday = MDAY_W'(cur.doy - month_start(cur.mp) + DOY_W'(1));
                if (cur.mp < MP_W'(MP_JANUARY))
                begin
                    nxt.month = cur.mp + MONTH_W'(MP_MARCH_ADD);
                    nxt.year  = cur.year;
                end
                else
                begin
                    nxt.month = cur.mp - MONTH_W'(MP_JAN_SUB);
                    nxt.year  = cur.year + YEAR_W'(1);
                end
            end
        end
    end

    // Load stage payloads
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS1; s++)
        begin
            if (ld[s])
            begin
                d1_rem_reg[s]  <= d1_rem_next[s];
                d1_work_reg[s] <= d1_work_next[s];
            end
        end
        for (int s = 0; s < NS2; s++)
        begin
            if (ld[D2_BASE + s])
            begin
                d2_rem_reg[s]  <= d2_rem_next[s];
                d2_work_reg[s] <= d2_work_next[s];
                d2_sod_reg[s]  <= d2_sod_next[s];
            end
        end
        for (int k = 0; k < TAIL_STAGES; k++)
        begin
            if (ld[TAIL_BASE + k])
            begin
                tail_reg[k] <= tail_next[k];
            end
        end
    end

    // Drive the result item
    assign cal_valid        = vld_reg[NST-1];
    assign second_of_minute = tail_reg[TAIL_STAGES-1].second;
    assign minute_of_hour   = tail_reg[TAIL_STAGES-1].minute;
    assign hour_of_day      = tail_reg[TAIL_STAGES-1].hour;
    assign weekday          = tail_reg[TAIL_STAGES-1].weekday;
    assign year_number      = tail_reg[TAIL_STAGES-1].year;
    assign month_number     = tail_reg[TAIL_STAGES-1].month;
    assign day_of_month     = tail_reg[TAIL_STAGES-1].mday;

    // Check division remainders and result ranges
    `ASSERT_NEVER(a_sod_range, clk, rst_n, vld_reg[NS1-1] && (d1_rem_reg[NS1-1] >= SOD_W'(SECONDS_PER_DAY)), "second of day out of range")
    `ASSERT_NEVER(a_doe_range, clk, rst_n, vld_reg[TAIL_BASE-1] && (d2_rem_reg[NS2-1] >= DOE_W'(ERA_DAYS)), "day of era out of range")
    `ASSERT_IMPLIES(a_time_range, clk, rst_n, cal_valid, (hour_of_day < HOUR_W'(HOURS_PER_DAY)) && (minute_of_hour < MIN_W'(SECONDS_PER_MINUTE)) && (second_of_minute < SEC_W'(SECONDS_PER_MINUTE)), "time of day out of range")
    `ASSERT_IMPLIES(a_date_range, clk, rst_n, cal_valid, (month_number != '0) && (month_number <= MONTH_W'(MONTHS_PER_YR)) && (day_of_month != '0) && (weekday != '0) && ((month_number != MONTH_W'(MONTH_FEB)) || (day_of_month <= MDAY_W'(FEB_MAX_DAYS))), "calendar date out of range")

endmodule
